[sv/pdr_pkg.sv]
// Shared types and constants for the PWM dimming ramp controller.
`default_nettype none

package pdr_pkg;

    localparam int LEVEL_W    = 10;
    localparam int AMOUNT_W   = 16;
    localparam int ELAPSED_W  = 17;
    localparam int INTERVAL_W = 8;
    localparam int ACTION_W   = 3;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [LEVEL_W-1:0]    MAX_LEVEL_RST      = LEVEL_W'(1000);
    localparam logic [LEVEL_W-1:0]    STEPDOWN_FLOOR_RST = LEVEL_W'(100);
    localparam logic [INTERVAL_W-1:0] RAMP_INTERVAL_RST  = INTERVAL_W'(10);
    localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX        = {ELAPSED_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 3'd0,
        ACT_SET       = 3'd1,
        ACT_STEP_UP   = 3'd2,
        ACT_STEP_DOWN = 3'd3,
        ACT_ON        = 3'd4,
        ACT_OFF       = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        REG_MAX_LEVEL      = 2'd0,
        REG_STEPDOWN_FLOOR = 2'd1,
        REG_RAMP_INTERVAL  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]    max_level;
        logic [LEVEL_W-1:0]    stepdown_floor;
        logic [INTERVAL_W-1:0] ramp_interval;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] duty;
        logic               lit;
        logic               ramping;
        logic               off_pending;
    } result_t;

endpackage

`default_nettype wire

[sv/pdr_cfg_regs.sv]
// APB configuration registers for the PWM dimming ramp controller.
`default_nettype none

module pdr_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pdr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [pdr_pkg::APB_DW-1:0]  pwdata,
    output logic      [pdr_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output pdr_pkg::cfg_t                    cfg
);

    pdr_pkg::cfg_t       cfg_reg;
    pdr_pkg::reg_index_t index;
    logic                wr_en;

    assign index  = pdr_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_level      <= pdr_pkg::MAX_LEVEL_RST;
            cfg_reg.stepdown_floor <= pdr_pkg::STEPDOWN_FLOOR_RST;
            cfg_reg.ramp_interval  <= pdr_pkg::RAMP_INTERVAL_RST;
        end else if (wr_en) begin
            case (index)
                pdr_pkg::REG_MAX_LEVEL: begin
                    cfg_reg.max_level <= pwdata[pdr_pkg::LEVEL_W-1:0];
                end
                pdr_pkg::REG_STEPDOWN_FLOOR: begin
                    cfg_reg.stepdown_floor <= pwdata[pdr_pkg::LEVEL_W-1:0];
                end
                pdr_pkg::REG_RAMP_INTERVAL: begin
                    cfg_reg.ramp_interval <= pwdata[pdr_pkg::INTERVAL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (index)
            pdr_pkg::REG_MAX_LEVEL: begin
                prdata = pdr_pkg::APB_DW'(cfg_reg.max_level);
            end
            pdr_pkg::REG_STEPDOWN_FLOOR: begin
                prdata = pdr_pkg::APB_DW'(cfg_reg.stepdown_floor);
            end
            pdr_pkg::REG_RAMP_INTERVAL: begin
                prdata = pdr_pkg::APB_DW'(cfg_reg.ramp_interval);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/pdr_core.sv]
// Dimming state and its combinational update for one item.
`default_nettype none

module pdr_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic [pdr_pkg::ACTION_W-1:0]  action,
    input  wire logic [pdr_pkg::AMOUNT_W-1:0]  amount,
    input  wire pdr_pkg::cfg_t                 cfg,
    output pdr_pkg::result_t                   result
);

    localparam int LW = pdr_pkg::LEVEL_W;
    localparam int AW = pdr_pkg::AMOUNT_W;
    localparam int EW = pdr_pkg::ELAPSED_W;
    localparam int IW = pdr_pkg::INTERVAL_W;

    logic [LW-1:0] level_reg,         level_next;
    logic [LW-1:0] duty_reg,          duty_next;
    logic [LW-1:0] target_reg,        target_next;
    logic          lit_reg,           lit_next;
    logic          off_wait_reg,      off_wait_next;
    logic [EW-1:0] off_elapsed_reg,   off_elapsed_next;
    logic [AW-1:0] off_limit_reg,     off_limit_next;
    logic [IW-1:0] prescale_reg,      prescale_next;

    pdr_pkg::action_t act;
    logic [EW-1:0]    elapsed_inc;
    logic [IW-1:0]    interval;
    logic [IW-1:0]    prescale_inc;
    logic [AW:0]      up_sum;
    logic [LW-1:0]    up_level;
    logic [LW-1:0]    set_level;
    logic [LW-1:0]    down_diff;
    logic [LW-1:0]    down_level;

    assign act          = pdr_pkg::action_t'(action);
    assign elapsed_inc  = (off_elapsed_reg < pdr_pkg::ELAPSED_MAX)
                          ? off_elapsed_reg + EW'(1) : off_elapsed_reg;
    assign interval     = (cfg.ramp_interval == '0) ? IW'(1) : cfg.ramp_interval;
    assign prescale_inc = prescale_reg + IW'(1);

    assign set_level = (amount > AW'(cfg.max_level)) ? cfg.max_level : amount[LW-1:0];
    assign up_sum    = (AW+1)'(amount) + (AW+1)'(level_reg);
    assign up_level  = (up_sum > (AW+1)'(cfg.max_level)) ? cfg.max_level
                                                          : up_sum[LW-1:0];
    assign down_diff  = level_reg - amount[LW-1:0];
    assign down_level = (down_diff < cfg.stepdown_floor) ? cfg.stepdown_floor
                                                         : down_diff;

    always_comb begin
        level_next       = level_reg;
        duty_next        = duty_reg;
        target_next      = target_reg;
        lit_next         = lit_reg;
        off_wait_next    = off_wait_reg;
        off_elapsed_next = off_elapsed_reg;
        off_limit_next   = off_limit_reg;
        prescale_next    = prescale_reg;
        case (act)
            pdr_pkg::ACT_TICK: begin
                if (off_wait_reg) begin
                    off_elapsed_next = elapsed_inc;
                end
                if (off_wait_reg && (elapsed_inc > EW'(off_limit_reg))) begin
                    off_wait_next = 1'b0;
                    duty_next     = level_reg;
                    target_next   = '0;
                    prescale_next = '0;
                end else if (duty_reg != target_reg) begin
                    if (prescale_inc >= interval) begin
                        prescale_next = '0;
                        if (duty_reg < target_reg) begin
                            duty_next = duty_reg + LW'(1);
                        end else begin
                            duty_next = duty_reg - LW'(1);
                        end
                    end else begin
                        prescale_next = prescale_inc;
                    end
                end
            end
            pdr_pkg::ACT_SET: begin
                duty_next     = set_level;
                target_next   = set_level;
                prescale_next = '0;
                lit_next      = (set_level != '0);
            end
            pdr_pkg::ACT_STEP_UP: begin
                if (up_level > level_reg) begin
                    duty_next     = level_reg;
                    target_next   = up_level;
                    prescale_next = '0;
                end
                level_next = up_level;
            end
            pdr_pkg::ACT_STEP_DOWN: begin
                if (AW'(level_reg) > amount) begin
                    if (down_level < level_reg) begin
                        duty_next     = level_reg;
                        target_next   = down_level;
                        prescale_next = '0;
                    end
                    level_next = down_level;
                end
            end
            pdr_pkg::ACT_ON: begin
                off_wait_next = 1'b0;
                if (!lit_reg) begin
                    lit_next      = 1'b1;
                    duty_next     = '0;
                    target_next   = level_reg;
                    prescale_next = '0;
                end
            end
            pdr_pkg::ACT_OFF: begin
                if (lit_reg) begin
                    lit_next         = 1'b0;
                    off_wait_next    = 1'b1;
                    off_limit_next   = amount;
                    off_elapsed_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg       <= '0;
            duty_reg        <= '0;
            target_reg      <= '0;
            lit_reg         <= 1'b0;
            off_wait_reg    <= 1'b0;
            off_elapsed_reg <= '0;
            off_limit_reg   <= '0;
            prescale_reg    <= '0;
        end else if (advance) begin
            level_reg       <= level_next;
            duty_reg        <= duty_next;
            target_reg      <= target_next;
            lit_reg         <= lit_next;
            off_wait_reg    <= off_wait_next;
            off_elapsed_reg <= off_elapsed_next;
            off_limit_reg   <= off_limit_next;
            prescale_reg    <= prescale_next;
        end
    end

    assign result.duty        = duty_next;
    assign result.lit         = lit_next;
    assign result.ramping     = (duty_next != target_next);
    assign result.off_pending = off_wait_next;

endmodule

`default_nettype wire

[sv/pwm_dimming_ramp_controller.sv]
// Top level of the PWM dimming ramp controller with input and result registers.
// An item waits in the input register and its result is held in the result register.
// One item per cycle while m_ready does not stall the output; the state update is a
// single pass of compare, add and clamp logic between input and result register.
// Reset clears the dimming state to zero and loads the register defaults.
`default_nettype none

module pwm_dimming_ramp_controller (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pdr_pkg::ACTION_W-1:0]  s_action,
    input  wire logic [pdr_pkg::AMOUNT_W-1:0]  s_amount,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pdr_pkg::LEVEL_W-1:0]   m_duty,
    output logic                               m_lit,
    output logic                               m_ramping,
    output logic                               m_off_pending,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pdr_pkg::APB_AW-1:0]    paddr,
    input  wire logic [pdr_pkg::APB_DW-1:0]    pwdata,
    output logic      [pdr_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    logic                          in_valid_reg;
    logic [pdr_pkg::ACTION_W-1:0]  in_action_reg;
    logic [pdr_pkg::AMOUNT_W-1:0]  in_amount_reg;
    logic                          out_valid_reg;
    pdr_pkg::result_t              out_reg;
    pdr_pkg::result_t              result;
    pdr_pkg::cfg_t                 cfg;
    logic                          advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    pdr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .action  (in_action_reg),
        .amount  (in_amount_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_amount_reg <= s_amount;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_duty        = out_reg.duty;
    assign m_lit         = out_reg.lit;
    assign m_ramping     = out_reg.ramping;
    assign m_off_pending = out_reg.off_pending;

endmodule

`default_nettype wire

[tb/pdr_checker.sv]
// Checker that predicts and compares every result of the PWM dimming ramp controller.
`timescale 1ns / 100ps

module pdr_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [pdr_pkg::ACTION_W-1:0]  s_action,
    input  wire logic [pdr_pkg::AMOUNT_W-1:0]  s_amount,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [pdr_pkg::LEVEL_W-1:0]   m_duty,
    input  wire logic                          m_lit,
    input  wire logic                          m_ramping,
    input  wire logic                          m_off_pending,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [pdr_pkg::APB_AW-1:0]    paddr,
    input  wire logic [pdr_pkg::APB_DW-1:0]    pwdata,
    output int                                 fail_count,
    output int                                 outstanding,
    output int                                 reports_checked
);
    import pdr_pkg::*;

    logic [LEVEL_W-1:0]    cfg_max;
    logic [LEVEL_W-1:0]    cfg_floor;
    logic [INTERVAL_W-1:0] cfg_interval;

    logic [LEVEL_W-1:0]    stored_level;
    logic [LEVEL_W-1:0]    duty_cnt;
    logic [LEVEL_W-1:0]    target_cnt;
    logic                  lit_on;
    logic                  off_armed;
    logic [ELAPSED_W-1:0]  off_count;
    logic [AMOUNT_W-1:0]   off_delay;
    logic [INTERVAL_W-1:0] ramp_div;

    result_t pending_reports[$];
    int      shown;

    task automatic begin_ramp(input logic [LEVEL_W-1:0] from_lvl,
                              input logic [LEVEL_W-1:0] to_lvl);
        duty_cnt   = from_lvl;
        target_cnt = to_lvl;
        ramp_div   = '0;
    endtask

    task automatic run_tick();
        logic [INTERVAL_W-1:0] ivl;
        logic                  expired;
        expired = 1'b0;
        if (off_armed) begin
            if (off_count != ELAPSED_MAX) begin
                off_count = off_count + 1'b1;
            end
            if (off_count > {1'b0, off_delay}) begin
                off_armed = 1'b0;
                begin_ramp(stored_level, '0);
                expired = 1'b1;
            end
        end
        if (!expired && duty_cnt != target_cnt) begin
            ivl = (cfg_interval == '0) ? INTERVAL_W'(1) : cfg_interval;
            ramp_div = ramp_div + 1'b1;
            if (ramp_div >= ivl) begin
                ramp_div = '0;
                if (duty_cnt < target_cnt) begin
                    duty_cnt = duty_cnt + 1'b1;
                end else begin
                    duty_cnt = duty_cnt - 1'b1;
                end
            end
        end
    endtask

    task automatic advance_dimmer(input logic [ACTION_W-1:0] act,
                                  input logic [AMOUNT_W-1:0] amt,
                                  output result_t rpt);
        logic [AMOUNT_W:0]  sum;
        logic [LEVEL_W-1:0] diff;
        logic [LEVEL_W-1:0] nl;
        case (act)
            ACT_TICK: begin
                run_tick();
            end
            ACT_SET: begin
                nl = (amt > cfg_max) ? cfg_max : amt[LEVEL_W-1:0];
                duty_cnt   = nl;
                target_cnt = nl;
                ramp_div   = '0;
                lit_on     = (nl != '0);
            end
            ACT_STEP_UP: begin
                sum = {1'b0, amt} + stored_level;
                nl = (sum > cfg_max) ? cfg_max : sum[LEVEL_W-1:0];
                if (nl > stored_level) begin
                    begin_ramp(stored_level, nl);
                end
                stored_level = nl;
            end
            ACT_STEP_DOWN: begin
                if (stored_level > amt) begin
                    diff = stored_level - amt[LEVEL_W-1:0];
                    nl = (diff < cfg_floor) ? cfg_floor : diff;
                    if (nl < stored_level) begin
                        begin_ramp(stored_level, nl);
                    end
                    stored_level = nl;
                end
            end
            ACT_ON: begin
                off_armed = 1'b0;
                if (!lit_on) begin
                    lit_on = 1'b1;
                    begin_ramp('0, stored_level);
                end
            end
            ACT_OFF: begin
                if (lit_on) begin
                    lit_on    = 1'b0;
                    off_armed = 1'b1;
                    off_delay = amt;
                    off_count = '0;
                end
            end
            default: begin
            end
        endcase
        rpt.duty        = duty_cnt;
        rpt.lit         = lit_on;
        rpt.ramping     = (duty_cnt != target_cnt);
        rpt.off_pending = off_armed;
    endtask

    always @(posedge aclk) begin : watch
        result_t seen;
        result_t want;
        if (!aresetn) begin
            cfg_max         = MAX_LEVEL_RST;
            cfg_floor       = STEPDOWN_FLOOR_RST;
            cfg_interval    = RAMP_INTERVAL_RST;
            stored_level    = '0;
            duty_cnt        = '0;
            target_cnt      = '0;
            lit_on          = 1'b0;
            off_armed       = 1'b0;
            off_count       = '0;
            off_delay       = '0;
            ramp_div        = '0;
            pending_reports.delete();
            outstanding     = 0;
            reports_checked = 0;
            fail_count      = 0;
            shown           = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[APB_AW-1:2]))
                    REG_MAX_LEVEL:      cfg_max      = pwdata[LEVEL_W-1:0];
                    REG_STEPDOWN_FLOOR: cfg_floor    = pwdata[LEVEL_W-1:0];
                    REG_RAMP_INTERVAL:  cfg_interval = pwdata[INTERVAL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                seen.duty        = m_duty;
                seen.lit         = m_lit;
                seen.ramping     = m_ramping;
                seen.off_pending = m_off_pending;
                reports_checked++;
                if (pending_reports.size() == 0) begin
                    fail_count++;
                    if (shown < 10) begin
                        $display("unexpected result: duty=%0d lit=%0b ramping=%0b off_pending=%0b",
                                 seen.duty, seen.lit, seen.ramping, seen.off_pending);
                    end
                    shown++;
                end else begin
                    want = pending_reports.pop_front();
                    if (seen.duty != want.duty || seen.lit != want.lit ||
                        seen.ramping != want.ramping ||
                        seen.off_pending != want.off_pending) begin
                        fail_count++;
                        if (shown < 10) begin
                            $display("mismatch at result %0d: expected duty=%0d lit=%0b ramping=%0b off_pending=%0b, got duty=%0d lit=%0b ramping=%0b off_pending=%0b",
                                     reports_checked, want.duty, want.lit, want.ramping,
                                     want.off_pending, seen.duty, seen.lit, seen.ramping,
                                     seen.off_pending);
                        end
                        shown++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_dimmer(s_action, s_amount, want);
                pending_reports.push_back(want);
            end
            outstanding = pending_reports.size();
        end
    end

endmodule

[tb/pwm_dimming_ramp_controller_tb.sv]
// Testbench top for the PWM dimming ramp controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module pwm_dimming_ramp_controller_tb;
    import pdr_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT = 300000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action;
    logic [AMOUNT_W-1:0]   s_amount;
    logic                  m_valid;
    logic                  m_ready;
    logic [LEVEL_W-1:0]    m_duty;
    logic                  m_lit;
    logic                  m_ramping;
    logic                  m_off_pending;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int fail_count;
    int outstanding;
    int reports_checked;
    int items_sent;
    int settings_used;
    int cycle_count;
    int cur_max;
    bit gaps_on;

    pwm_dimming_ramp_controller u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_amount      (s_amount),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty        (m_duty),
        .m_lit         (m_lit),
        .m_ramping     (m_ramping),
        .m_off_pending (m_off_pending),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pdr_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_amount        (s_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_duty          (m_duty),
        .m_lit           (m_lit),
        .m_ramping       (m_ramping),
        .m_off_pending   (m_off_pending),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .reports_checked (reports_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic logic [AMOUNT_W-1:0] amount_for(input logic [ACTION_W-1:0] act);
        logic [AMOUNT_W-1:0] anything;
        anything = AMOUNT_W'($urandom);
        case (act)
            ACT_SET: begin
                return ($urandom_range(0, 4) == 0) ? anything
                                                   : AMOUNT_W'($urandom_range(0, cur_max + cur_max / 4 + 2));
            end
            ACT_STEP_UP, ACT_STEP_DOWN: begin
                return ($urandom_range(0, 4) == 0) ? anything
                                                   : AMOUNT_W'($urandom_range(0, cur_max / 3 + 2));
            end
            ACT_OFF: begin
                return ($urandom_range(0, 9) == 0) ? anything : AMOUNT_W'($urandom_range(0, 20));
            end
            default: begin
                return anything;
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken
    // with valid still high, so the caller must follow with another item or a drain.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [AMOUNT_W-1:0] amt);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_amount <= amt;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int max_lvl, input int floor_lvl, input int ivl);
        drain();
        apb_write(REG_MAX_LEVEL, APB_DW'(max_lvl));
        apb_write(REG_STEPDOWN_FLOOR, APB_DW'(floor_lvl));
        apb_write(REG_RAMP_INTERVAL, APB_DW'(ivl));
        @(negedge aclk);
        cur_max = max_lvl;
        settings_used++;
    endtask

    // Well-formed dimming sequences and tick runs with random content, but mostly single random items.
    task automatic run_random(input int count);
        int left;
        int pick;
        int delay;
        int run_len;
        logic [ACTION_W-1:0] act;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                delay = $urandom_range(0, 12);
                send_item(ACT_ON, amount_for(ACT_ON));
                send_item(ACT_STEP_UP, amount_for(ACT_STEP_UP));
                send_item(ACT_OFF, AMOUNT_W'(delay));
                repeat (delay + 2) send_item(ACT_TICK, amount_for(ACT_TICK));
                left -= delay + 5;
            end else if (pick < 27) begin
                run_len = $urandom_range(8, 40);
                repeat (run_len) send_item(ACT_TICK, amount_for(ACT_TICK));
                left -= run_len;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40) act = ACT_TICK;
                else if (pick < 50) act = ACT_SET;
                else if (pick < 62) act = ACT_STEP_UP;
                else if (pick < 74) act = ACT_STEP_DOWN;
                else if (pick < 86) act = ACT_ON;
                else if (pick < 94) act = ACT_OFF;
                else if (pick < 97) act = ACT_SPARE_A;
                else act = ACT_SPARE_B;
                send_item(act, amount_for(act));
                left--;
            end
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_action <= ACT_TICK;
        s_amount <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        gaps_on  = 1'b1;
        cur_max  = MAX_LEVEL_RST;
        settings_used = 1;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset register values.
        send_item(ACT_TICK, '0);
        send_item(ACT_ON, '0);
        send_item(ACT_STEP_UP, AMOUNT_W'(300));
        repeat (5) send_item(ACT_TICK, '1);
        send_item(ACT_SET, '1);
        send_item(ACT_SET, '0);
        send_item(ACT_STEP_UP, '1);
        send_item(ACT_STEP_DOWN, '1);
        send_item(ACT_STEP_DOWN, AMOUNT_W'(1));
        send_item(ACT_STEP_DOWN, AMOUNT_W'(950));
        send_item(ACT_ON, '0);
        send_item(ACT_OFF, '0);
        send_item(ACT_TICK, '0);
        send_item(ACT_TICK, '0);
        send_item(ACT_ON, '0);
        send_item(ACT_OFF, AMOUNT_W'(3));
        send_item(ACT_ON, '0);
        send_item(ACT_SPARE_A, '1);
        send_item(ACT_SPARE_B, '0);
        send_item(ACT_SET, AMOUNT_W'(1));
        send_item(ACT_STEP_UP, '0);
        send_item(ACT_OFF, '1);
        send_item(ACT_ON, '1);

        configure(60, 4, 1);
        run_random(140);
        configure(1023, 1023, 255);
        run_random(60);
        configure(1, 0, 0);
        gaps_on = 1'b0;
        run_random(60);
        configure(0, 0, 3);
        gaps_on = 1'b1;
        run_random(30);
        configure(200, 20, 2);
        run_random(160);
        gaps_on = 1'b0;
        run_random(100);
        drain();
        repeat (10) @(negedge aclk);

        $display("Run covered %0d items under %0d register settings; %0d results were checked.",
                 items_sent, settings_used, reports_checked);
        $display("Stimulus mixed ramps, clamps, floors, delayed turn-off expiry and spare codes.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
